// ----- sv/dtg_pkg.sv -----
package dtg_pkg;

  // Phase and table geometry
  localparam int PHASE_W     = 32;
  localparam int SINE_DEPTH  = 1024;
  localparam int IDX_W       = $clog2(SINE_DEPTH);
  localparam int QUARTER     = SINE_DEPTH / 4;
  localparam int HALF_DEPTH  = SINE_DEPTH / 2;
  localparam int QIDX_W      = $clog2(QUARTER + 1);

  // Field widths
  localparam int STEP_W      = 31;
  localparam int LEVEL_W     = 15;
  localparam int SAMPLE_W    = 16;
  localparam int MAG_W       = 16;
  localparam int PROD_W      = MAG_W + LEVEL_W - 1;
  localparam int CONTRIB_W   = PROD_W - 15;
  localparam int SUM_W       = CONTRIB_W + 2;
  localparam int SAT_HI      = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAT_LO      = -(2 ** (SAMPLE_W - 1));

  // Tick queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_ONE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TWO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ONE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TWO = 2'd3;
  localparam int CFG_DATA_W = STEP_W;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // One request as handed from front to back
  typedef struct packed {
    logic [IDX_W-1:0] idx_one;
    logic [IDX_W-1:0] idx_two;
    logic             on_one;
    logic             on_two;
  } tick_t;

  typedef logic [MAG_W-1:0] sine_quarter_t [QUARTER+1];

  // Quarter-wave magnitude table, Q30 Taylor series to x^13, rounded to Q15
  function automatic sine_quarter_t build_sine();
    sine_quarter_t      tbl;
    longint unsigned    u;
    longint unsigned    x;
    longint unsigned    x2;
    longint unsigned    t;
    longint             s;
    longint             q;
    for (int m = 0; m <= QUARTER; m++) begin
      u = 64'(4 * m);
      x = (PI_HALF_Q30 * u) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      t = x;
      s = longint'(x);
      t = ((t * x2) >> 30) / 6;   s = s - longint'(t);
      t = ((t * x2) >> 30) / 20;  s = s + longint'(t);
      t = ((t * x2) >> 30) / 42;  s = s - longint'(t);
      t = ((t * x2) >> 30) / 72;  s = s + longint'(t);
      t = ((t * x2) >> 30) / 110; s = s - longint'(t);
      t = ((t * x2) >> 30) / 156; s = s + longint'(t);
      if (s < 0) s = 0;
      q = (s + 16384) >>> 15;
      tbl[m] = MAG_W'(q);
    end
    return tbl;
  endfunction

  localparam sine_quarter_t SINE_QUARTER = build_sine();

endpackage

// ----- sv/dtg_in_if.sv -----
interface dtg_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic silence;

  modport source (output valid, output start_req, output silence, input ready);
  modport sink   (input valid, input start_req, input silence, output ready);
endinterface

// ----- sv/dtg_out_if.sv -----
interface dtg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dtg_pkg::SAMPLE_W-1:0] sample;
  logic                                all_quiet;

  modport source (output valid, output sample, output all_quiet, input ready);
  modport sink   (input valid, input sample, input all_quiet, output ready);
endinterface

// ----- sv/dtg_front.sv -----
module dtg_front (
  input  logic                         clk,
  input  logic                         rst_n,
  dtg_in_if.sink                       in_ch,
  input  logic [dtg_pkg::STEP_W-1:0]   step_one,
  input  logic [dtg_pkg::STEP_W-1:0]   step_two,
  input  logic                         q_full,
  output logic                         push,
  output dtg_pkg::tick_t               push_data
);

  localparam logic [dtg_pkg::PHASE_W-1:0] HALF_TURN =
    {1'b1, {(dtg_pkg::PHASE_W-1){1'b0}}};

  logic [dtg_pkg::PHASE_W-1:0] ph_one_r, ph_one_nxt;
  logic [dtg_pkg::PHASE_W-1:0] ph_two_r, ph_two_nxt;
  logic                        on_one_r, on_one_nxt;
  logic                        on_two_r, on_two_nxt;
  logic                        stop_r,   stop_nxt;

  logic [dtg_pkg::PHASE_W-1:0] ph_one, ph_two;
  logic [dtg_pkg::PHASE_W-1:0] stp_one, stp_two;
  logic                        on_one, on_two;
  logic                        accept;

  // within one step of a crossing at 0 or half a turn
  function automatic logic near_cross(input logic [dtg_pkg::PHASE_W-1:0] ph,
                                      input logic [dtg_pkg::PHASE_W-1:0] stp);
    logic [dtg_pkg::PHASE_W-1:0] h;
    h = {1'b0, ph[dtg_pkg::PHASE_W-2:0]};
    return (h <= stp) || ((HALF_TURN - h) <= stp);
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign stp_one     = dtg_pkg::PHASE_W'(step_one);
  assign stp_two     = dtg_pkg::PHASE_W'(step_two);

  always_comb begin
    ph_one   = in_ch.start_req ? '0 : ph_one_r;
    ph_two   = in_ch.start_req ? '0 : ph_two_r;
    on_one   = in_ch.start_req ? 1'b1 : on_one_r;
    on_two   = in_ch.start_req ? 1'b1 : on_two_r;
    stop_nxt = in_ch.silence || (!in_ch.start_req && stop_r);
    if (stop_nxt && on_one && near_cross(ph_one, stp_one)) begin
      on_one = 1'b0;
      ph_one = '0;
    end
    if (stop_nxt && on_two && near_cross(ph_two, stp_two)) begin
      on_two = 1'b0;
      ph_two = '0;
    end
    ph_one_nxt = on_one ? ph_one + stp_one : ph_one;
    ph_two_nxt = on_two ? ph_two + stp_two : ph_two;
    on_one_nxt = on_one;
    on_two_nxt = on_two;
  end

  assign push              = accept;
  assign push_data.idx_one = ph_one[dtg_pkg::PHASE_W-1 -: dtg_pkg::IDX_W];
  assign push_data.idx_two = ph_two[dtg_pkg::PHASE_W-1 -: dtg_pkg::IDX_W];
  assign push_data.on_one  = on_one;
  assign push_data.on_two  = on_two;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_one_r <= '0;
      ph_two_r <= '0;
      on_one_r <= 1'b0;
      on_two_r <= 1'b0;
      stop_r   <= 1'b1;
    end else if (accept) begin
      ph_one_r <= ph_one_nxt;
      ph_two_r <= ph_two_nxt;
      on_one_r <= on_one_nxt;
      on_two_r <= on_two_nxt;
      stop_r   <= stop_nxt;
    end
  end

endmodule

// ----- sv/dtg_queue.sv -----
module dtg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dtg_pkg::tick_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output dtg_pkg::tick_t head
);

  dtg_pkg::tick_t              mem_r [dtg_pkg::QUEUE_DEPTH];
  logic [dtg_pkg::QPTR_W-1:0]  wr_r, wr_nxt;
  logic [dtg_pkg::QPTR_W-1:0]  rd_r, rd_nxt;
  logic [dtg_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        do_pop;

  localparam logic [dtg_pkg::QPTR_W-1:0] LAST = dtg_pkg::QPTR_W'(dtg_pkg::QUEUE_DEPTH - 1);
  localparam logic [dtg_pkg::QCNT_W-1:0] FULL_CNT = dtg_pkg::QCNT_W'(dtg_pkg::QUEUE_DEPTH);

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_nxt  = push   ? ((wr_r == LAST) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop ? ((rd_r == LAST) ? '0 : rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

// ----- sv/dtg_back.sv -----
module dtg_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_not_empty,
  input  dtg_pkg::tick_t              q_head,
  output logic                        q_pop,
  input  logic [dtg_pkg::LEVEL_W-1:0] level_one,
  input  logic [dtg_pkg::LEVEL_W-1:0] level_two,
  dtg_out_if.source                   out_ch
);

  // stage 1: folded table lookup
  logic                        v1_r;
  logic [dtg_pkg::MAG_W-1:0]   mag_one_r, mag_two_r;
  logic                        neg_one_r, neg_two_r;
  logic                        on_one_r,  on_two_r;
  // stage 2: product
  logic                        v2_r;
  logic [dtg_pkg::PROD_W-1:0]  prod_one_r, prod_two_r;
  logic                        neg_one2_r, neg_two2_r;
  logic                        on_one2_r,  on_two2_r;
  // stage 3: output
  logic                        out_v_r;
  logic signed [dtg_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                        quiet_r;

  logic                        en;
  logic [dtg_pkg::QIDX_W-1:0]  qi_one, qi_two;
  logic [dtg_pkg::CONTRIB_W-1:0] c_one, c_two;
  logic signed [dtg_pkg::SUM_W-1:0] s_one, s_two, sum;

  localparam logic signed [dtg_pkg::SUM_W-1:0] SAT_HI = dtg_pkg::SUM_W'(dtg_pkg::SAT_HI);
  localparam logic signed [dtg_pkg::SUM_W-1:0] SAT_LO = dtg_pkg::SUM_W'(dtg_pkg::SAT_LO);

  // fold an index onto the first quarter wave
  function automatic logic [dtg_pkg::QIDX_W-1:0] fold(input logic [dtg_pkg::IDX_W-1:0] idx);
    logic [dtg_pkg::IDX_W-1:0] r;
    r = {1'b0, idx[dtg_pkg::IDX_W-2:0]};
    if (r > dtg_pkg::IDX_W'(dtg_pkg::QUARTER)) r = dtg_pkg::IDX_W'(dtg_pkg::HALF_DEPTH) - r;
    return r[dtg_pkg::QIDX_W-1:0];
  endfunction

  assign en     = !out_v_r || out_ch.ready;
  assign q_pop  = en;
  assign qi_one = fold(q_head.idx_one);
  assign qi_two = fold(q_head.idx_two);

  always_comb begin
    c_one = prod_one_r[dtg_pkg::PROD_W-1 -: dtg_pkg::CONTRIB_W];
    c_two = prod_two_r[dtg_pkg::PROD_W-1 -: dtg_pkg::CONTRIB_W];
    s_one = on_one2_r ? $signed({2'b00, c_one}) : '0;
    s_two = on_two2_r ? $signed({2'b00, c_two}) : '0;
    if (neg_one2_r) s_one = -s_one;
    if (neg_two2_r) s_two = -s_two;
    sum = s_one + s_two;
    if (sum > SAT_HI)      sample_nxt = SAT_HI[dtg_pkg::SAMPLE_W-1:0];
    else if (sum < SAT_LO) sample_nxt = SAT_LO[dtg_pkg::SAMPLE_W-1:0];
    else                   sample_nxt = sum[dtg_pkg::SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v1_r    <= q_not_empty;
      v2_r    <= v1_r;
      out_v_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_one_r  <= dtg_pkg::SINE_QUARTER[qi_one];
      mag_two_r  <= dtg_pkg::SINE_QUARTER[qi_two];
      neg_one_r  <= q_head.idx_one[dtg_pkg::IDX_W-1];
      neg_two_r  <= q_head.idx_two[dtg_pkg::IDX_W-1];
      on_one_r   <= q_head.on_one;
      on_two_r   <= q_head.on_two;
      prod_one_r <= mag_one_r * level_one[dtg_pkg::LEVEL_W-1:1];
      prod_two_r <= mag_two_r * level_two[dtg_pkg::LEVEL_W-1:1];
      neg_one2_r <= neg_one_r;
      neg_two2_r <= neg_two_r;
      on_one2_r  <= on_one_r;
      on_two2_r  <= on_two_r;
      sample_r   <= sample_nxt;
      quiet_r    <= !on_one2_r && !on_two2_r;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.sample    = sample_r;
  assign out_ch.all_quiet = quiet_r;

endmodule

// ----- sv/dual_tone_generator.sv -----
// Two-tone phase-accumulator source, one signed sample per accepted request.
// An accepted request is queued, then passes the lookup, product and output registers.
// Throughput: one request per cycle while the queue is not full; the front updates phases
// on each accepted request and the back (table lookup, multiply, sum) is a three-stage stalling pipeline.
// Reset (synchronous, rst_n low): phases and config cleared, oscillators off,
// stopping mode set, queue and pipeline empty. No clearing pass is needed.
module dual_tone_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  dtg_in_if.sink                           in_ch,
  dtg_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [dtg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dtg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Configuration registers; the user must write them only while the block is idle; not enforced here
  logic [dtg_pkg::STEP_W-1:0]  step_one_r, step_two_r;
  logic [dtg_pkg::LEVEL_W-1:0] level_one_r, level_two_r;

  // Front to queue, queue to back
  logic           push, q_full, q_not_empty, q_pop;
  dtg_pkg::tick_t push_data, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_one_r  <= '0;
      step_two_r  <= '0;
      level_one_r <= '0;
      level_two_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtg_pkg::CFG_STEP_ONE:  step_one_r  <= cfg_wdata;
        dtg_pkg::CFG_STEP_TWO:  step_two_r  <= cfg_wdata;
        dtg_pkg::CFG_LEVEL_ONE: level_one_r <= cfg_wdata[dtg_pkg::LEVEL_W-1:0];
        dtg_pkg::CFG_LEVEL_TWO: level_two_r <= cfg_wdata[dtg_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: start/silence handling, zero-crossing stop, phase advance
  dtg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .step_one  (step_one_r),
    .step_two  (step_two_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Short queue so the front keeps taking requests while the output stalls, until the queue is full
  dtg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back: sine lookup, level scaling, sum with saturation, output register
  dtg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .level_one   (level_one_r),
    .level_two   (level_two_r),
    .out_ch      (out_ch)
  );

endmodule
